### rtl/vmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VU meter package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package vmpc_pkg;

  localparam int LEVEL_WIDTH      = 15;
  localparam int COEFF_WIDTH      = 16;
  localparam int LENGTH_WIDTH     = 20;
  localparam int CFG_DATA_WIDTH   = 20;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int QUEUE_DEPTH      = 2;

  localparam int DEF_SAMPLE_WIDTH     = 16;
  localparam int DEF_HOLD_COUNT_WIDTH = 20;

  localparam logic [COEFF_WIDTH-1:0]  PEAK_DECAY      = 16'd65470;
  localparam logic [LEVEL_WIDTH-1:0]  FULL_SCALE      = 15'h7FFF;

  localparam logic [COEFF_WIDTH-1:0]  RST_ATTACK      = 16'd6554;
  localparam logic [COEFF_WIDTH-1:0]  RST_RELEASE     = 16'd66;
  localparam logic [LENGTH_WIDTH-1:0] RST_PEAK_HOLD   = 20'd24000;
  localparam logic [LENGTH_WIDTH-1:0] RST_CLIP_HOLD   = 20'd48000;
  localparam logic [LEVEL_WIDTH-1:0]  RST_CLIP_THRESH = 15'd32440;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ATTACK_COEFF     = 3'd0,
    CFG_RELEASE_COEFF    = 3'd1,
    CFG_PEAK_HOLD_LENGTH = 3'd2,
    CFG_CLIP_HOLD_LENGTH = 3'd3,
    CFG_CLIP_LEVEL       = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [COEFF_WIDTH-1:0]  attack_coeff;
    logic [COEFF_WIDTH-1:0]  release_coeff;
    logic [LENGTH_WIDTH-1:0] peak_hold_length;
    logic [LENGTH_WIDTH-1:0] clip_hold_length;
    logic [LEVEL_WIDTH-1:0]  clip_level;
  } cfg_t;

  typedef struct packed {
    logic                   push;
    logic [LEVEL_WIDTH-1:0] data;
  } q_push_t;

  typedef struct packed {
    logic                   valid;
    logic [LEVEL_WIDTH-1:0] data;
  } q_head_t;

endpackage

### rtl/vmpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VU meter front end
// Accepts samples, rectifies and scales them to Q0.15, clamps to full scale
// and holds the result until the queue takes it.
// ----------------------------------------------------------------------------
module vmpc_front #(
  parameter int SAMPLE_WIDTH = vmpc_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    q_full,
  output vmpc_pkg::q_push_t       q_push
);
  import vmpc_pkg::*;

  logic                    valid_r;
  logic                    valid_nxt;
  logic [LEVEL_WIDTH-1:0]  mag_r;
  logic [SAMPLE_WIDTH-1:0] abs_val;
  logic [15:0]             scaled;
  logic [LEVEL_WIDTH-1:0]  clamped;
  logic                    take;
  logic                    push;

  always_comb begin
    if (in_sample[SAMPLE_WIDTH-1]) begin
      abs_val = SAMPLE_WIDTH'(~in_sample) + SAMPLE_WIDTH'(1);
    end else begin
      abs_val = in_sample;
    end
  end

  generate
    if (SAMPLE_WIDTH >= 16) begin : g_shift_down
      assign scaled = abs_val[SAMPLE_WIDTH-1 -: 16];
    end else begin : g_shift_up
      assign scaled = {abs_val, {(16 - SAMPLE_WIDTH){1'b0}}};
    end
  endgenerate

  assign clamped  = scaled[15] ? FULL_SCALE : scaled[LEVEL_WIDTH-1:0];
  assign in_stall = valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = valid_r && !q_full;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag_r <= clamped;
    end
  end

  assign q_push.push = push;
  assign q_push.data = mag_r;

endmodule

### rtl/vmpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VU meter queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module vmpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  vmpc_pkg::q_push_t q_push,
  output logic              q_full,
  input  logic              q_pop,
  output vmpc_pkg::q_head_t q_head
);
  import vmpc_pkg::*;

  localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  logic [LEVEL_WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr_r;
  logic [PTR_WIDTH-1:0]   wr_ptr_nxt;
  logic [PTR_WIDTH-1:0]   rd_ptr_r;
  logic [PTR_WIDTH-1:0]   rd_ptr_nxt;
  logic [CNT_WIDTH-1:0]   count_r;
  logic [CNT_WIDTH-1:0]   count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign q_full       = (count_r == CNT_WIDTH'(QUEUE_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.data  = entry_r[rd_ptr_r];
  assign do_push      = q_push.push && !q_full;
  assign do_pop       = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_WIDTH'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_WIDTH'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_WIDTH'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_push.data;
    end
  end

endmodule

### rtl/vmpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VU meter back end
// Updates the envelope, peak hold and clip indicator for each rectified
// sample and registers the result transaction.
// ----------------------------------------------------------------------------
module vmpc_back #(
  parameter int HOLD_COUNT_WIDTH = vmpc_pkg::DEF_HOLD_COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vmpc_pkg::cfg_t                    cfg,
  input  vmpc_pkg::q_head_t                 q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vmpc_pkg::LEVEL_WIDTH-1:0]  out_level,
  output logic [vmpc_pkg::LEVEL_WIDTH-1:0]  out_peak,
  output logic                              out_clipping
);
  import vmpc_pkg::*;

  localparam int PROD_WIDTH = LEVEL_WIDTH + COEFF_WIDTH;

  logic [LEVEL_WIDTH-1:0]      env_r;
  logic [LEVEL_WIDTH-1:0]      env_nxt;
  logic [LEVEL_WIDTH-1:0]      peak_r;
  logic [LEVEL_WIDTH-1:0]      peak_nxt;
  logic [HOLD_COUNT_WIDTH-1:0] peak_cnt_r;
  logic [HOLD_COUNT_WIDTH-1:0] peak_cnt_nxt;
  logic [HOLD_COUNT_WIDTH-1:0] clip_cnt_r;
  logic [HOLD_COUNT_WIDTH-1:0] clip_cnt_nxt;
  logic                        clip_r;
  logic                        clip_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [LEVEL_WIDTH-1:0]      out_level_r;
  logic [LEVEL_WIDTH-1:0]      out_peak_r;
  logic                        out_clip_r;

  logic                        rising;
  logic [LEVEL_WIDTH-1:0]      diff;
  logic [COEFF_WIDTH-1:0]      coeff;
  logic [PROD_WIDTH-1:0]       step_prod;
  logic [PROD_WIDTH-1:0]       decay_prod;
  logic [LEVEL_WIDTH-1:0]      step;
  logic [HOLD_COUNT_WIDTH-1:0] peak_len;
  logic [HOLD_COUNT_WIDTH-1:0] clip_len;

  assign q_pop    = q_head.valid && (!out_valid_r || !out_stall);
  assign peak_len = HOLD_COUNT_WIDTH'(cfg.peak_hold_length);
  assign clip_len = HOLD_COUNT_WIDTH'(cfg.clip_hold_length);

  // One multiplier serves both directions of the envelope step.
  assign rising     = q_head.data > env_r;
  assign diff       = rising ? (q_head.data - env_r) : (env_r - q_head.data);
  assign coeff      = rising ? cfg.attack_coeff : cfg.release_coeff;
  assign step_prod  = PROD_WIDTH'(diff) * PROD_WIDTH'(coeff);
  assign step       = step_prod[PROD_WIDTH-1 -: LEVEL_WIDTH];
  assign decay_prod = PROD_WIDTH'(peak_r) * PROD_WIDTH'(PEAK_DECAY);

  always_comb begin
    env_nxt = rising ? (env_r + step) : (env_r - step);
  end

  always_comb begin
    peak_nxt     = peak_r;
    peak_cnt_nxt = peak_cnt_r;
    if (env_nxt > peak_r) begin
      peak_nxt     = env_nxt;
      peak_cnt_nxt = peak_len;
    end else if (peak_cnt_r != '0) begin
      peak_cnt_nxt = peak_cnt_r - HOLD_COUNT_WIDTH'(1);
    end else begin
      peak_nxt = decay_prod[PROD_WIDTH-1 -: LEVEL_WIDTH];
    end
  end

  always_comb begin
    clip_nxt     = clip_r;
    clip_cnt_nxt = clip_cnt_r;
    if (env_nxt >= cfg.clip_level) begin
      clip_nxt     = 1'b1;
      clip_cnt_nxt = clip_len;
    end else if (clip_cnt_r != '0) begin
      clip_cnt_nxt = clip_cnt_r - HOLD_COUNT_WIDTH'(1);
      if (clip_cnt_r == HOLD_COUNT_WIDTH'(1)) begin
        clip_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r       <= '0;
      peak_r      <= '0;
      peak_cnt_r  <= '0;
      clip_cnt_r  <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        env_r      <= env_nxt;
        peak_r     <= peak_nxt;
        peak_cnt_r <= peak_cnt_nxt;
        clip_cnt_r <= clip_cnt_nxt;
        clip_r     <= clip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_level_r <= env_nxt;
      out_peak_r  <= peak_nxt;
      out_clip_r  <= clip_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_peak     = out_peak_r;
  assign out_clipping = out_clip_r;

endmodule

### rtl/vu_meter_envelope_peak_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VU meter with envelope follower, peak hold and clip indicator
// Holds the configuration registers and joins the front end, the queue and
// the back end.
//
//   Port group  Direction  Transaction
//   in_*        input      one signed audio sample
//   out_*       output     level, peak and clip flag after that sample
//   cfg_*       input      one register write, no handshake
//
// One sample is accepted per cycle when the output is not stalled.
// A result is presented after its sample passes the front register, the
// queue entry and then the result register.
// The envelope step multiplier in the back end is combinational, so the
// per-sample recurrence closes at each envelope register update.
// Reset clears the control state and loads the register defaults; the data registers are not reset.
// An output stall fills the two-entry queue and then stalls the input.
// ----------------------------------------------------------------------------
module vu_meter_envelope_peak_clip #(
  parameter int SAMPLE_WIDTH     = vmpc_pkg::DEF_SAMPLE_WIDTH,
  parameter int HOLD_COUNT_WIDTH = vmpc_pkg::DEF_HOLD_COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_WIDTH-1:0]              in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [vmpc_pkg::LEVEL_WIDTH-1:0]     out_level,
  output logic [vmpc_pkg::LEVEL_WIDTH-1:0]     out_peak,
  output logic                                 out_clipping,
  input  logic                                 cfg_we,
  input  logic [vmpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [vmpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
  import vmpc_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_COEFF: begin
          cfg_nxt.attack_coeff = cfg_wdata[COEFF_WIDTH-1:0];
        end
        CFG_RELEASE_COEFF: begin
          cfg_nxt.release_coeff = cfg_wdata[COEFF_WIDTH-1:0];
        end
        CFG_PEAK_HOLD_LENGTH: begin
          cfg_nxt.peak_hold_length = cfg_wdata[LENGTH_WIDTH-1:0];
        end
        CFG_CLIP_HOLD_LENGTH: begin
          cfg_nxt.clip_hold_length = cfg_wdata[LENGTH_WIDTH-1:0];
        end
        CFG_CLIP_LEVEL: begin
          cfg_nxt.clip_level = cfg_wdata[LEVEL_WIDTH-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coeff     <= RST_ATTACK;
      cfg_r.release_coeff    <= RST_RELEASE;
      cfg_r.peak_hold_length <= RST_PEAK_HOLD;
      cfg_r.clip_hold_length <= RST_CLIP_HOLD;
      cfg_r.clip_level       <= RST_CLIP_THRESH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vmpc_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  vmpc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  vmpc_back #(
    .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_peak     (out_peak),
    .out_clipping (out_clipping)
  );

endmodule
